@@ rtl/vps_pkg.sv @@
// shared types and constants of the vertex projection unit
`default_nettype none

package vps_pkg;

	// field widths fixed by the item formats
	localparam int COORD_W  = 32;
	localparam int SIZE_W   = 14;
	localparam int MINW_W   = 31;
	localparam int SCREEN_W = 16;
	localparam int DEPTH_W  = 32;
	localparam int MAT_N    = 16;
	localparam int MAT_IDX_W = 4;

	// quotient bits resolved by the pixel divider
	localparam int QB = 17;

	// operation codes
	localparam logic OP_TRANSFORM = 1'b0;
	localparam logic OP_LOAD      = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_W         = 2'd2;

	// register reset values
	localparam logic [SIZE_W-1:0] WIDTH_RST  = 14'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 14'd480;
	localparam logic [MINW_W-1:0] MIN_W_RST  = 31'd655;

	// saturation limits
	localparam logic [SCREEN_W-1:0] SCR_POS_MAX = 16'h7fff;
	localparam logic [SCREEN_W-1:0] SCR_NEG_MIN = 16'h8000;
	localparam logic [QB-1:0]       Q_POS_LIM   = 17'd32767;
	localparam logic [QB-1:0]       Q_NEG_LIM   = 17'd32768;
	localparam logic [DEPTH_W-1:0]  DEPTH_MAX   = 32'h7fffffff;

	typedef struct packed {
		logic                        operation;
		logic signed [COORD_W-1:0]   coord_x;
		logic signed [COORD_W-1:0]   coord_y;
		logic signed [COORD_W-1:0]   coord_z;
		logic [MAT_IDX_W-1:0]        coeff_index;
		logic signed [COORD_W-1:0]   coeff_value;
	} vertex_item_t;

	typedef struct packed {
		logic signed [SCREEN_W-1:0] screen_x;
		logic signed [SCREEN_W-1:0] screen_y;
		logic signed [DEPTH_W-1:0]  depth_w;
		logic                       too_close;
		logic                       behind_near;
		logic                       clamped;
	} pixel_item_t;

endpackage

`default_nettype wire

@@ rtl/vps_stream_if.sv @@
// valid/ready stream channel carrying one item
`default_nettype none

interface vps_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/vertex_project_to_screen_unit.sv @@
// vertex transform, perspective divide and viewport mapping pipeline
`default_nettype none

// Takes one item per clock while the output is not stalled. A transform item
// multiplies (x, y, z, 1) by the stored column-major 4x4 matrix and leaves as
// one pixel item through one multiply stage, one sum stage, three stages
// to form numerators, magnitudes and the scaled products, one range check,
// 17 compare-subtract stages of the pixel divider, and the output register.
// The divider is fully pipelined, so the sustained rate is one item per
// cycle; a stall on the output freezes the whole pipe. A load item writes one
// coefficient in the cycle it is accepted and gives no result; a transform
// uses the matrix as it stands at its own acceptance. Coefficients have no
// reset value and must be loaded before the first transform.
module vertex_project_to_screen_unit
	import vps_pkg::*;
#(
	parameter int COORD_FRAC_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	vps_stream_if.sink                 vtx,
	vps_stream_if.source               pix,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PROD_W = 2 * COORD_W;
	localparam int TERM_W = PROD_W - COORD_FRAC_BITS;
	localparam int CLIP_W = TERM_W + 2;
	localparam int N_W    = CLIP_W + 1;
	localparam int P_W    = N_W + SIZE_W;
	localparam int D_W    = CLIP_W;
	localparam int R_W    = ((P_W > D_W + QB) ? P_W : D_W + QB) + 1;
	localparam int LAST   = 7 + QB;

	typedef struct packed {
		logic          neg;
		logic          ovf;
		logic [QB-1:0] q;
		logic [R_W-1:0] rem;
	} axis_t;

	typedef struct packed {
		logic               close;
		logic               behind;
		logic               dsat;
		logic [DEPTH_W-1:0] depth;
	} side_t;

	// configuration registers
	logic [SIZE_W-1:0] width_q, height_q;
	logic [MINW_W-1:0] min_w_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			min_w_q  <= MIN_W_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCREEN_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
				CFG_SCREEN_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				CFG_MIN_W:         min_w_q  <= cfg_data[MINW_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline advance and acceptance
	logic adv, take, load;
	logic vld_s [1:LAST];

	assign adv      = !vld_s[LAST] || pix.ready;
	assign vtx.ready = adv;
	assign take     = vtx.valid && adv && (vtx.data.operation == OP_TRANSFORM);
	assign load     = vtx.valid && adv && (vtx.data.operation == OP_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAST; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= take;
			for (int i = 2; i <= LAST; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// coefficient store
	logic signed [COORD_W-1:0] coeff_q [MAT_N];

	always_ff @(posedge clk) begin
		if (load) coeff_q[vtx.data.coeff_index] <= vtx.data.coeff_value;
	end

	// stage 1: twelve products and the translation column
	logic signed [PROD_W-1:0]  prod_s1  [3][4];
	logic signed [COORD_W-1:0] trans_s1 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				prod_s1[0][r] <= PROD_W'(coeff_q[r])     * PROD_W'(vtx.data.coord_x);
				prod_s1[1][r] <= PROD_W'(coeff_q[4 + r]) * PROD_W'(vtx.data.coord_y);
				prod_s1[2][r] <= PROD_W'(coeff_q[8 + r]) * PROD_W'(vtx.data.coord_z);
				trans_s1[r]   <= coeff_q[12 + r];
			end
		end
	end

	// stage 2: floor-shifted products summed into clip coordinates
	logic signed [CLIP_W-1:0] clip_s2 [4];
	logic signed [TERM_W-1:0] term [3][4];

	always_comb begin
		for (int c = 0; c < 3; c++)
			for (int r = 0; r < 4; r++)
				term[c][r] = TERM_W'(prod_s1[c][r] >>> COORD_FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++)
				clip_s2[r] <= CLIP_W'(term[0][r]) + CLIP_W'(term[1][r])
					+ CLIP_W'(term[2][r]) + CLIP_W'(trans_s1[r]);
		end
	end

	// stage 3: numerators, divisor and flags
	logic signed [N_W-1:0]    nx_s3, ny_s3;
	logic [D_W-1:0]           d_s3;
	side_t                    side_s3;
	logic signed [CLIP_W:0]   zw_sum;
	logic signed [CLIP_W-1:0] cw;
	logic                     cw_big;

	assign cw     = clip_s2[3];
	assign zw_sum = (CLIP_W+1)'(clip_s2[2]) + (CLIP_W+1)'(cw);
	assign cw_big = cw > $signed(CLIP_W'(DEPTH_MAX));

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s3          <= N_W'(cw) + N_W'(clip_s2[0]);
			ny_s3          <= N_W'(cw) - N_W'(clip_s2[1]);
			d_s3           <= {cw[CLIP_W-2:0], 1'b0};
			side_s3.close  <= (cw <= 0) || (cw < $signed(CLIP_W'(min_w_q)));
			side_s3.behind <= zw_sum < 0;
			side_s3.dsat   <= cw_big;
			side_s3.depth  <= cw_big ? DEPTH_MAX : cw[DEPTH_W-1:0];
		end
	end

	// stage 4: sign and magnitude of the numerators
	logic [N_W-1:0] magx_s4, magy_s4;
	logic           negx_s4, negy_s4;
	logic [D_W-1:0] d_s4;
	side_t          side_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			negx_s4 <= nx_s3 < 0;
			negy_s4 <= ny_s3 < 0;
			magx_s4 <= (nx_s3 < 0) ? N_W'(-nx_s3) : N_W'(nx_s3);
			magy_s4 <= (ny_s3 < 0) ? N_W'(-ny_s3) : N_W'(ny_s3);
			d_s4    <= d_s3;
			side_s4 <= side_s3;
		end
	end

	// stage 5: scale by viewport size
	logic [P_W-1:0] px_s5, py_s5;
	logic           negx_s5, negy_s5;
	logic [D_W-1:0] d_s5;
	side_t          side_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s5   <= P_W'(magx_s4) * P_W'(width_q);
			py_s5   <= P_W'(magy_s4) * P_W'(height_q);
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;
			d_s5    <= d_s4;
			side_s5 <= side_s4;
		end
	end

	// stage 6: quotient range check, divider entry
	axis_t          divx_s [0:QB];
	axis_t          divy_s [0:QB];
	logic [R_W-1:0] dv_s   [0:QB];
	side_t          side_s [0:QB];
	logic [R_W-1:0] d_top;

	assign d_top = R_W'(d_s5) << QB;

	always_ff @(posedge clk) begin
		if (adv) begin
			divx_s[0] <= '{neg: negx_s5, ovf: R_W'(px_s5) >= d_top, q: '0, rem: R_W'(px_s5)};
			divy_s[0] <= '{neg: negy_s5, ovf: R_W'(py_s5) >= d_top, q: '0, rem: R_W'(py_s5)};
			dv_s[0]   <= R_W'(d_s5);
			side_s[0] <= side_s5;
		end
	end

	function automatic axis_t div_step(input axis_t a, input logic [R_W-1:0] dv,
		input int b);
		axis_t          res;
		logic [R_W-1:0] trial;
		res   = a;
		trial = dv << b;
		if (a.rem >= trial) begin
			res.rem  = a.rem - trial;
			res.q[b] = 1'b1;
		end
		return res;
	endfunction

	// stages 7 and on: one quotient bit per stage, most significant first
	for (genvar k = 0; k < QB; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				divx_s[k+1] <= div_step(divx_s[k], dv_s[k], QB - 1 - k);
				divy_s[k+1] <= div_step(divy_s[k], dv_s[k], QB - 1 - k);
				dv_s[k+1]   <= dv_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	// signed, saturated pixel from quotient magnitude: {sat, value}
	function automatic logic [SCREEN_W:0] fold(input axis_t a);
		logic [SCREEN_W:0] res;
		if (!a.neg) begin
			if (a.ovf || a.q > Q_POS_LIM) res = {1'b1, SCR_POS_MAX};
			else                          res = {1'b0, a.q[SCREEN_W-1:0]};
		end else begin
			if (a.ovf || a.q > Q_NEG_LIM) res = {1'b1, SCR_NEG_MIN};
			else                          res = {1'b0, SCREEN_W'(-a.q)};
		end
		return res;
	endfunction

	// output register
	logic [SCREEN_W:0] fx, fy;
	side_t             sd;
	pixel_item_t       pix_s;

	assign fx = fold(divx_s[QB]);
	assign fy = fold(divy_s[QB]);
	assign sd = side_s[QB];

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s.behind_near <= sd.behind;
			pix_s.too_close   <= sd.close;
			if (sd.close) begin
				pix_s.screen_x <= '0;
				pix_s.screen_y <= '0;
				pix_s.depth_w  <= '0;
				pix_s.clamped  <= 1'b0;
			end else begin
				pix_s.screen_x <= fx[SCREEN_W-1:0];
				pix_s.screen_y <= fy[SCREEN_W-1:0];
				pix_s.depth_w  <= sd.depth;
				pix_s.clamped  <= fx[SCREEN_W] || fy[SCREEN_W] || sd.dsat;
			end
		end
	end

	assign pix.valid = vld_s[LAST];
	assign pix.data  = pix_s;

	// a load item never enters the pipe
	a_load_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> !vld_s[1])
		else $error("load item entered the transform pipe");

	// a too-close item carries zero position and depth and no clamp
	a_close_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.data.too_close |-> pix.data.screen_x == 0
			&& pix.data.screen_y == 0 && pix.data.depth_w == 0 && !pix.data.clamped)
		else $error("too-close item has nonzero fields");

	// a stalled output stops intake
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && !pix.ready |-> !vtx.ready)
		else $error("input taken while output stalled");

endmodule

`default_nettype wire
